// ----- design/glct_pkg.sv -----
// Package for the grid likelihood count table.
// Holds the sequencer state type, op codes and fixed-point constants.
// No dependencies.
package glct_pkg;

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_READ    = 8'b0000_0100,
    S_EXEC    = 8'b0000_1000,
    S_DIV     = 8'b0001_0000,
    S_FIN     = 8'b0010_0000,
    S_SUM_RD  = 8'b0100_0000,
    S_SUM_ACC = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_QUERY = 2'd1,
    OP_NORM  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [31:0] PROB_ONE  = 32'h0100_0000;
  localparam logic [31:0] FRAC_0999 = 32'h00FF_BE77;
  localparam int unsigned DIV_W     = 56;
  localparam int unsigned DIV_CNT_W = 6;

endpackage

// ----- design/grid_likelihood_count_table_unit.sv -----
// Grid likelihood count table: count update, ratio query and row normalize.
// Operations run one at a time with busy high; a query ends with the result strobe
// as busy falls, and normalize sums the row over all bins, then divides each bin's counts by the row sums.
// Queries and normalize share one radix-2 divider, 56 iterations per quotient.
// Reset (rst, synchronous) starts a clearing pass over all GRID_W*GRID_H*COUNT_BINS
// entries with busy high; the result receiver cannot stall.
// Depends on glct_pkg.
module grid_likelihood_count_table_unit #(
  parameter int GRID_W     = 16,
  parameter int GRID_H     = 16,
  parameter int COUNT_BINS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [3:0]  cell_x,
  input  logic [3:0]  cell_y,
  input  logic [3:0]  search_x,
  input  logic [3:0]  search_y,
  input  logic [7:0]  face_count,
  input  logic [3:0]  rect_x,
  input  logic [3:0]  rect_y,
  input  logic [4:0]  rect_w,
  input  logic [4:0]  rect_h,
  output logic        valid,
  output logic [31:0] ratio,
  output logic [3:0]  out_x,
  output logic [3:0]  out_y
);

  localparam int DEPTH = GRID_W * GRID_H * COUNT_BINS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW    = (COUNT_BINS > 1) ? $clog2(COUNT_BINS) : 1;
  localparam int SW    = 32 + $clog2(COUNT_BINS + 1);
  localparam int DW    = glct_pkg::DIV_W;
  localparam int CW    = glct_pkg::DIV_CNT_W;

  glct_pkg::state_t state;
  glct_pkg::op_t    op_q;

  logic [31:0] face_cnt_mem   [DEPTH];
  logic [31:0] noface_cnt_mem [DEPTH];
  logic [31:0] face_prb_mem   [DEPTH];
  logic [31:0] noface_prb_mem [DEPTH];

  logic [31:0] cf_rd, cn_rd, pf_rd, pn_rd;
  logic [AW-1:0] addr, base, clr_idx;
  logic [BW-1:0] bin, clr_bin;
  logic          in_face, tsel;
  logic [3:0]    cx_q, cy_q;
  logic [SW-1:0] sum_f, sum_n, dvs;
  logic [SW-1:0] rem;
  logic [SW:0]   trial;
  logic [DW-1:0] quo;
  logic [CW-1:0] div_cnt;
  logic [31:0]   quo_sat;

  // accept-time address
  logic [3:0]    dx, dy;
  logic [31:0]   offx, offy, fbin, idx_i, nbase_i;
  logic [5:0]    rx_end, ry_end;
  logic          inside_i;

  always_comb begin
    dx = (search_x > cell_x) ? search_x - cell_x : cell_x - search_x;
    dy = (search_y > cell_y) ? search_y - cell_y : cell_y - search_y;
    offx = (32'(dx) >= 32'(GRID_W)) ? 32'(GRID_W - 1) : 32'(dx);
    offy = (32'(dy) >= 32'(GRID_H)) ? 32'(GRID_H - 1) : 32'(dy);
    fbin = (32'(face_count) < 32'(COUNT_BINS)) ? 32'(face_count) : 32'(COUNT_BINS - 1);
    idx_i = (offy * 32'(GRID_W) + offx) * 32'(COUNT_BINS) + fbin;
    nbase_i = (((32'(cell_y) >= 32'(GRID_H)) ? 32'(GRID_H - 1) : 32'(cell_y))
               * 32'(GRID_W)
               + ((32'(cell_x) >= 32'(GRID_W)) ? 32'(GRID_W - 1) : 32'(cell_x)))
              * 32'(COUNT_BINS);
    rx_end = 6'(rect_x) + 6'(rect_w);
    ry_end = 6'(rect_y) + 6'(rect_h);
    inside_i = (cell_x >= rect_x) && (6'(cell_x) < rx_end) &&
               (cell_y >= rect_y) && (6'(cell_y) < ry_end);
  end

  assign busy    = (state != glct_pkg::S_IDLE);
  assign trial   = {rem, quo[DW-1]};
  assign quo_sat = (|quo[DW-1:32]) ? 32'hFFFF_FFFF : quo[31:0];

  // memory write ports
  logic          cf_we, cn_we, pf_we, pn_we;
  logic [AW-1:0] wa;
  logic [31:0]   cnt_wd, pf_wd, pn_wd;

  always_comb begin
    cf_we = 1'b0; cn_we = 1'b0; pf_we = 1'b0; pn_we = 1'b0;
    wa = addr; cnt_wd = 32'd0; pf_wd = 32'd0; pn_wd = 32'd0;
    unique case (state)
      glct_pkg::S_CLEAR: begin
        cf_we = 1'b1; cn_we = 1'b1; pf_we = 1'b1; pn_we = 1'b1;
        wa = clr_idx;
        cnt_wd = 32'd1;
        pf_wd = {8'(32'(clr_bin) * 5), 24'd0} + glct_pkg::FRAC_0999;
        pn_wd = glct_pkg::PROB_ONE;
      end
      glct_pkg::S_EXEC: begin
        if (op_q == glct_pkg::OP_COUNT) begin
          cf_we = in_face;
          cn_we = !in_face;
          cnt_wd = in_face ? ((&cf_rd) ? cf_rd : cf_rd + 32'd1)
                           : ((&cn_rd) ? cn_rd : cn_rd + 32'd1);
        end
      end
      glct_pkg::S_FIN: begin
        if (op_q == glct_pkg::OP_NORM) begin
          pf_we = !tsel;
          pn_we = tsel;
          pf_wd = (dvs == '0) ? 32'd0 : quo_sat;
          pn_wd = (dvs == '0) ? 32'd0 : quo_sat;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cf_we) face_cnt_mem[wa] <= cnt_wd;
    cf_rd <= face_cnt_mem[addr];
  end
  always_ff @(posedge clk) begin
    if (cn_we) noface_cnt_mem[wa] <= cnt_wd;
    cn_rd <= noface_cnt_mem[addr];
  end
  always_ff @(posedge clk) begin
    if (pf_we) face_prb_mem[wa] <= pf_wd;
    pf_rd <= face_prb_mem[addr];
  end
  always_ff @(posedge clk) begin
    if (pn_we) noface_prb_mem[wa] <= pn_wd;
    pn_rd <= noface_prb_mem[addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= glct_pkg::S_CLEAR;
      clr_idx <= '0;
      clr_bin <= '0;
      valid   <= 1'b0;
      op_q    <= glct_pkg::OP_NONE;
    end else begin
      valid <= 1'b0;
      unique case (state)
        glct_pkg::S_CLEAR: begin
          if (clr_idx == AW'(DEPTH - 1)) begin
            state <= glct_pkg::S_IDLE;
          end
          clr_idx <= clr_idx + 1'b1;
          clr_bin <= (clr_bin == BW'(COUNT_BINS - 1)) ? '0 : clr_bin + 1'b1;
        end
        glct_pkg::S_IDLE: begin
          if (start) begin
            op_q    <= glct_pkg::op_t'(op);
            cx_q    <= cell_x;
            cy_q    <= cell_y;
            in_face <= inside_i;
            tsel    <= 1'b0;
            bin     <= '0;
            sum_f   <= '0;
            sum_n   <= '0;
            priority case (glct_pkg::op_t'(op))
              glct_pkg::OP_COUNT, glct_pkg::OP_QUERY: begin
                addr  <= AW'(idx_i);
                state <= glct_pkg::S_READ;
              end
              glct_pkg::OP_NORM: begin
                addr  <= AW'(nbase_i);
                base  <= AW'(nbase_i);
                state <= glct_pkg::S_SUM_RD;
              end
              default: state <= glct_pkg::S_IDLE;
            endcase
          end
        end
        glct_pkg::S_SUM_RD: state <= glct_pkg::S_SUM_ACC;
        glct_pkg::S_SUM_ACC: begin
          sum_f <= sum_f + SW'(cf_rd);
          sum_n <= sum_n + SW'(cn_rd);
          if (bin == BW'(COUNT_BINS - 1)) begin
            bin   <= '0;
            addr  <= base;
            state <= glct_pkg::S_READ;
          end else begin
            bin   <= bin + 1'b1;
            addr  <= addr + 1'b1;
            state <= glct_pkg::S_SUM_RD;
          end
        end
        glct_pkg::S_READ: state <= glct_pkg::S_EXEC;
        glct_pkg::S_EXEC: begin
          rem     <= '0;
          div_cnt <= '0;
          if (op_q == glct_pkg::OP_COUNT) begin
            state <= glct_pkg::S_IDLE;
          end else if (op_q == glct_pkg::OP_QUERY) begin
            quo   <= {8'd0, pf_rd, 16'd0};
            dvs   <= SW'(pn_rd);
            state <= glct_pkg::S_DIV;
          end else begin
            quo   <= tsel ? {cn_rd, 24'd0} : {cf_rd, 24'd0};
            dvs   <= tsel ? sum_n : sum_f;
            state <= glct_pkg::S_DIV;
          end
        end
        glct_pkg::S_DIV: begin
          if (trial >= {1'b0, dvs}) begin
            rem <= SW'(trial - {1'b0, dvs});
            quo <= {quo[DW-2:0], 1'b1};
          end else begin
            rem <= SW'(trial);
            quo <= {quo[DW-2:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == CW'(DW - 1)) state <= glct_pkg::S_FIN;
        end
        glct_pkg::S_FIN: begin
          if (op_q == glct_pkg::OP_QUERY) begin
            valid <= 1'b1;
            ratio <= quo_sat;
            out_x <= cx_q;
            out_y <= cy_q;
            state <= glct_pkg::S_IDLE;
          end else if (!tsel) begin
            tsel  <= 1'b1;
            state <= glct_pkg::S_EXEC;
          end else begin
            tsel <= 1'b0;
            if (bin == BW'(COUNT_BINS - 1)) begin
              state <= glct_pkg::S_IDLE;
            end else begin
              bin   <= bin + 1'b1;
              addr  <= addr + 1'b1;
              state <= glct_pkg::S_READ;
            end
          end
        end
        default: state <= glct_pkg::S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_clear_busy: assert property (@(posedge clk) $past(rst) |-> busy)
    else $error("busy low right after reset");
  a_valid_query: assert property (@(posedge clk) disable iff (rst)
    valid |-> (op_q == glct_pkg::OP_QUERY))
    else $error("result strobe from non-query transaction");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == glct_pkg::S_DIV) |-> (div_cnt < CW'(DW)))
    else $error("divider overran");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && glct_pkg::op_t'(op) != glct_pkg::OP_NONE) |=> busy)
    else $error("accepted transaction did not raise busy");
`endif

endmodule
